// ===== sv/lcs_pkg.sv =====
// Package for the least-loaded processor select unit: widths, codes and types.
`timescale 1ns / 1ps
`default_nettype none
package lcs_pkg;

    localparam int MAX_CPUS = 64;
    localparam int CPU_W    = 6;
    localparam int CNT_W    = 7;
    localparam int DEPTH_W  = 10;
    localparam int LOAD_W   = 11;
    localparam int HOW_W    = 2;

    typedef logic [CPU_W-1:0]    cpu_t;
    typedef logic [LOAD_W-1:0]   load_t;
    typedef logic [DEPTH_W-1:0]  depth_t;
    typedef logic [HOW_W-1:0]    how_t;
    typedef logic [MAX_CPUS-1:0] cpu_mask_t;
    typedef logic [CNT_W-1:0]    count_t;

    localparam logic FUNC_UPDATE = 1'b0;
    localparam logic FUNC_PICK   = 1'b1;

    localparam how_t HOW_LEAST   = 2'd0;
    localparam how_t HOW_PREF    = 2'd1;
    localparam how_t HOW_FIRST   = 2'd2;
    localparam how_t HOW_DEFAULT = 2'd3;

    localparam depth_t MAX_QUEUE_DEPTH = 10'd1023;

endpackage
`default_nettype wire

// ===== sv/lcs_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module lcs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule
`default_nettype wire

// ===== sv/least_loaded_cpu_select_unit.sv =====
// Least-loaded processor select unit: record table, serial scan and result register.
//
// Usage:
//   Input channel (in_valid / in_stall) carries one word per handshake. func 0
//   writes one processor record (depth, busy, present, online) and gives no
//   result; func 1 picks a processor for the given affinity mask and preferred
//   processor and gives exactly one result word on the output channel.
//   The processor count is written through cfg_wr_en / cfg_wr_data; the user
//   must write it only while idle, the unit itself does not enforce this. A
//   pick scans the records one per cycle through the depth RAM read port, one
//   per active processor, then passes a wait state and loads the result into
//   the output register once it is free (skipping the scan when no processor
//   is allowed), and the next word is accepted the cycle after.
//   Reset clears all flags, sets the processor count to 1 and empties the output
//   register; the depth RAM is not cleared, a record is only used once its
//   present flag was set by an update. If the receiver stalls, the result
//   waits in the output register while input is still accepted; a second
//   result waits in the unit until the register frees up.
`timescale 1ns / 1ps
`default_nettype none
module least_loaded_cpu_select_unit (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_wr_en,
    input  wire lcs_pkg::count_t       cfg_wr_data,
    input  wire logic                  in_valid,
    output logic                       in_stall,
    input  wire logic                  func,
    input  wire lcs_pkg::cpu_t         cpu_index,
    input  wire lcs_pkg::depth_t       queue_depth,
    input  wire logic                  busy_req,
    input  wire logic                  cpu_present,
    input  wire logic                  cpu_online,
    input  wire lcs_pkg::cpu_mask_t    allowed_mask,
    input  wire lcs_pkg::cpu_t         pref_cpu,
    output logic                       out_valid,
    input  wire logic                  out_stall,
    output lcs_pkg::cpu_t              chosen_cpu,
    output lcs_pkg::load_t             chosen_load,
    output lcs_pkg::how_t              how_chosen
);
    import lcs_pkg::*;

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SCAN   = 2'd1;
    localparam logic [1:0] ST_WAIT   = 2'd2;
    localparam logic [1:0] ST_RESULT = 2'd3;

    logic [1:0] state_reg, state_next;
    count_t     num_cpus_reg, num_cpus_next;
    cpu_mask_t  present_reg, present_next;
    cpu_mask_t  online_reg, online_next;
    logic       out_valid_reg, out_valid_next;
    logic       p1_act_reg, p1_act_next;
    logic       found_reg, found_next;
    logic       first_found_reg, first_found_next;

    cpu_mask_t  qual_sh_reg, qual_sh_next;
    cpu_mask_t  allow_sh_reg, allow_sh_next;
    cpu_t       cnt_reg, cnt_next;
    cpu_t       last_reg, last_next;
    cpu_t       pref_reg, pref_next;
    logic       pref_ok_reg, pref_ok_next;
    logic       p1_qual_reg, p1_qual_next;
    cpu_t       p1_cpu_reg, p1_cpu_next;
    cpu_t       best_reg, best_next;
    load_t      best_load_reg, best_load_next;
    cpu_t       first_reg, first_next;
    cpu_t       out_cpu_reg, out_cpu_next;
    load_t      out_load_reg, out_load_next;
    how_t       out_how_reg, out_how_next;

    logic [DEPTH_W:0] rd_word;
    cpu_t      last_idx;
    cpu_mask_t allowed;
    load_t     rd_load;
    logic      accept;
    logic      upd_we;
    logic      can_load;

    always_comb
    begin
        if (num_cpus_reg == '0)
        begin
            last_idx = '0;
        end
        else if (num_cpus_reg > count_t'(MAX_CPUS))
        begin
            last_idx = cpu_t'(MAX_CPUS - 1);
        end
        else
        begin
            last_idx = cpu_t'(num_cpus_reg - count_t'(1));
        end
    end

    assign in_stall = (state_reg != ST_IDLE);
    assign accept   = in_valid && !in_stall;
    assign upd_we   = accept && (func == FUNC_UPDATE);
    assign allowed  = ((allowed_mask != '0) ? allowed_mask : online_reg) & online_reg;
    assign can_load = !out_valid_reg || !out_stall;
    assign rd_load  = load_t'(rd_word[DEPTH_W-1:0]) + load_t'(rd_word[DEPTH_W]);

    lcs_ram #(
        .WIDTH (DEPTH_W + 1),
        .DEPTH (MAX_CPUS)
    ) u_depth_ram (
        .clk     (clk),
        .wr_en   (upd_we),
        .wr_addr (cpu_index),
        .wr_data ({busy_req, (queue_depth > MAX_QUEUE_DEPTH) ? MAX_QUEUE_DEPTH : queue_depth}),
        .rd_addr (cnt_reg),
        .rd_data (rd_word)
    );

    always_comb
    begin
        state_next       = state_reg;
        num_cpus_next    = num_cpus_reg;
        present_next     = present_reg;
        online_next      = online_reg;
        out_valid_next   = out_valid_reg;
        p1_act_next      = 1'b0;
        found_next       = found_reg;
        first_found_next = first_found_reg;
        qual_sh_next     = qual_sh_reg;
        allow_sh_next    = allow_sh_reg;
        cnt_next         = cnt_reg;
        last_next        = last_reg;
        pref_next        = pref_reg;
        pref_ok_next     = pref_ok_reg;
        p1_qual_next     = p1_qual_reg;
        p1_cpu_next      = p1_cpu_reg;
        best_next        = best_reg;
        best_load_next   = best_load_reg;
        first_next       = first_reg;
        out_cpu_next     = out_cpu_reg;
        out_load_next    = out_load_reg;
        out_how_next     = out_how_reg;

        if (cfg_wr_en)
        begin
            num_cpus_next = cfg_wr_data;
        end

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        // compare stage, one record behind the RAM address
        if (p1_act_reg && p1_qual_reg)
        begin
            if (!found_reg || (rd_load < best_load_reg) ||
                ((rd_load == best_load_reg) && (p1_cpu_reg == pref_reg)))
            begin
                found_next     = 1'b1;
                best_next      = p1_cpu_reg;
                best_load_next = rd_load;
            end
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (upd_we)
                begin
                    present_next[cpu_index] = cpu_present;
                    online_next[cpu_index]  = cpu_online;
                end
                else if (accept)
                begin
                    qual_sh_next     = allowed & present_reg & online_reg;
                    allow_sh_next    = allowed;
                    cnt_next         = '0;
                    last_next        = last_idx;
                    pref_next        = pref_cpu;
                    found_next       = 1'b0;
                    first_found_next = 1'b0;
                    if (allowed == '0)
                    begin
                        pref_ok_next = (pref_cpu <= last_idx);
                        state_next   = ST_RESULT;
                    end
                    else
                    begin
                        pref_ok_next = (pref_cpu <= last_idx) && allowed[pref_cpu];
                        state_next   = ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                p1_act_next   = 1'b1;
                p1_qual_next  = qual_sh_reg[0];
                p1_cpu_next   = cnt_reg;
                qual_sh_next  = qual_sh_reg >> 1;
                allow_sh_next = allow_sh_reg >> 1;
                if (!first_found_reg && allow_sh_reg[0])
                begin
                    first_found_next = 1'b1;
                    first_next       = cnt_reg;
                end
                if (cnt_reg == last_reg)
                begin
                    state_next = ST_WAIT;
                end
                else
                begin
                    cnt_next = cnt_reg + cpu_t'(1);
                end
            end
            ST_WAIT:
            begin
                state_next = ST_RESULT;
            end
            ST_RESULT:
            begin
                if (can_load)
                begin
                    out_valid_next = 1'b1;
                    out_load_next  = '0;
                    if (found_reg)
                    begin
                        out_cpu_next  = best_reg;
                        out_load_next = best_load_reg;
                        out_how_next  = HOW_LEAST;
                    end
                    else if (pref_ok_reg)
                    begin
                        out_cpu_next = pref_reg;
                        out_how_next = HOW_PREF;
                    end
                    else if (first_found_reg)
                    begin
                        out_cpu_next = first_reg;
                        out_how_next = HOW_FIRST;
                    end
                    else
                    begin
                        out_cpu_next = '0;
                        out_how_next = HOW_DEFAULT;
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            num_cpus_reg    <= count_t'(1);
            present_reg     <= '0;
            online_reg      <= '0;
            out_valid_reg   <= 1'b0;
            p1_act_reg      <= 1'b0;
            found_reg       <= 1'b0;
            first_found_reg <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            num_cpus_reg    <= num_cpus_next;
            present_reg     <= present_next;
            online_reg      <= online_next;
            out_valid_reg   <= out_valid_next;
            p1_act_reg      <= p1_act_next;
            found_reg       <= found_next;
            first_found_reg <= first_found_next;
        end
    end

    always_ff @(posedge clk)
    begin
        qual_sh_reg   <= qual_sh_next;
        allow_sh_reg  <= allow_sh_next;
        cnt_reg       <= cnt_next;
        last_reg      <= last_next;
        pref_reg      <= pref_next;
        pref_ok_reg   <= pref_ok_next;
        p1_qual_reg   <= p1_qual_next;
        p1_cpu_reg    <= p1_cpu_next;
        best_reg      <= best_next;
        best_load_reg <= best_load_next;
        first_reg     <= first_next;
        out_cpu_reg   <= out_cpu_next;
        out_load_reg  <= out_load_next;
        out_how_reg   <= out_how_next;
    end

    assign out_valid   = out_valid_reg;
    assign chosen_cpu  = out_cpu_reg;
    assign chosen_load = out_load_reg;
    assign how_chosen  = out_how_reg;

endmodule
`default_nettype wire
